/* hdl/bitmap_block_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Concurrent assertion wrappers clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define BBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap block allocator check failed");

`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap block allocator check failed");

`else

`define BBA_ASSERT_SAME(label, ante, cons)

`define BBA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths and request and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BLOCK_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT      = 2'd1;

endpackage

/* hdl/bba_req_if.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator request channel
// Valid and ready handshake carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface bba_req_if;

  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [bba_pkg::BLOCK_W-1:0]  block_index;
  logic                         run_last;

  modport source (output valid, output req_type, output block_index, output run_last,
                  input ready);
  modport sink   (input valid, input req_type, input block_index, input run_last,
                  output ready);

endinterface

/* hdl/bba_rsp_if.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator result channel
// Valid and ready handshake carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface bba_rsp_if;

  logic                          valid;
  logic                          ready;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic [bba_pkg::BLOCK_W-1:0]   block_number;
  logic [bba_pkg::COUNT_W-1:0]   used_blocks;
  logic                          run_last_out;

  modport source (output valid, output status, output block_number, output used_blocks,
                  output run_last_out, input ready);
  modport sink   (input valid, input status, input block_number, input used_blocks,
                  input run_last_out, output ready);

endinterface

/* hdl/bitmap_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// First-fit allocator over a used-bit map kept in an internal word memory.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An allocate request scans the bitmap
// words from the one holding the first data block to the one holding the last
// block below the limit and stops at the first free bit; a request that finds an
// empty range fails without a scan, and a free checks and clears one bit. The
// scan reads one bitmap word per cycle through the single read port
// of the map memory and searches it with one priority encoder. Results wait in
// an output register, so a new request is taken while a result is unclaimed.
// MAP_WORD_BITS must be a power of two. The map is empty after reset with no
// clearing pass, since each word carries a valid bit.
module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS    = 4096,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bba_req_if.sink                         req,
  bba_rsp_if.source                       rsp,
  input  logic                            cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int BW        = $clog2(MAP_WORD_BITS);
  localparam int NBW       = $clog2(NUM_BLOCKS + 1);
  localparam int LW        = (NBW > bba_pkg::COUNT_W) ? NBW : bba_pkg::COUNT_W;
  localparam int BLOCK_W   = bba_pkg::BLOCK_W;
  localparam int COUNT_W   = bba_pkg::COUNT_W;
  localparam int STATUS_W  = bba_pkg::STATUS_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FCHK = 5'b00100,
    S_PUSH = 5'b01000,
    S_FAIL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [BLOCK_W-1:0]        fdb_q;
  logic [COUNT_W-1:0]        limit_q;
  logic [NBW-1:0]            used_q, used_d;

  logic [AW-1:0]             word_q, word_d;
  logic                      first_q, first_d;
  logic [AW-1:0]             last_word_q, last_word_d;
  logic [BW-1:0]             start_lo_q, start_lo_d;
  logic [BW-1:0]             lim_lo_q, lim_lo_d;
  logic [BLOCK_W-1:0]        idx_q, idx_d;
  logic                      idx_bad_q, idx_bad_d;
  logic                      last_q, last_d;

  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic [BLOCK_W-1:0]        res_blk_q, res_blk_d;

  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       out_status_q;
  logic [BLOCK_W-1:0]        out_blk_q;
  logic [COUNT_W-1:0]        out_used_q;
  logic                      out_last_q;
  logic                      out_load;

  logic [MAP_WORD_BITS-1:0]  mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]      vld_q;
  logic [MAP_WORD_BITS-1:0]  rd_data_q;
  logic                      rd_vld_q;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [MAP_WORD_BITS-1:0]  mem_wdata;

  logic [MAP_WORD_BITS-1:0]  map_word;
  logic [MAP_WORD_BITS-1:0]  avail;
  logic                      found;
  logic [BW-1:0]             found_bit;
  logic [MAP_WORD_BITS-1:0]  bit_mask;

  logic [BLOCK_W-1:0]        start_blk;
  logic [LW-1:0]             lim;
  logic [LW-1:0]             lim_m1;
  logic                      range_empty;
  logic                      req_fire;

  assign req.ready = (state_q == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  assign start_blk   = (fdb_q == '0) ? BLOCK_W'(1) : fdb_q;
  assign lim         = (LW'(limit_q) > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : LW'(limit_q);
  assign lim_m1      = lim - LW'(1);
  assign range_empty = (LW'(start_blk) >= lim);

  assign map_word = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q   <= BLOCK_W'(1);
      limit_q <= COUNT_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bba_pkg::CFG_FIRST_DATA_BLOCK: fdb_q   <= cfg_data_i[BLOCK_W-1:0];
        bba_pkg::CFG_BLOCK_LIMIT:      limit_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[mem_waddr] <= 1'b1;
    end
  end

  always_comb begin
    logic lo_ok;
    logic hi_ok;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      lo_ok    = !first_q || (BW'(i) >= start_lo_q);
      hi_ok    = (word_q != last_word_q) || (BW'(i) <= lim_lo_q);
      avail[i] = !map_word[i] && lo_ok && hi_ok;
    end
  end

  always_comb begin
    found     = 1'b0;
    found_bit = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found     = 1'b1;
        found_bit = BW'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    first_d      = first_q;
    last_word_d  = last_word_q;
    start_lo_d   = start_lo_q;
    lim_lo_d     = lim_lo_q;
    idx_d        = idx_q;
    idx_bad_d    = idx_bad_q;
    last_d       = last_q;
    res_status_d = res_status_q;
    res_blk_d    = res_blk_q;
    used_d       = used_q;
    rd_addr      = AW'(LW'(start_blk) >> BW);
    mem_we       = 1'b0;
    mem_waddr    = word_q;
    mem_wdata    = map_word;
    bit_mask     = '0;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req.req_type == bba_pkg::REQ_FREE) begin
          rd_addr = AW'(req.block_index >> BW);
        end
        if (req_fire) begin
          idx_d       = req.block_index;
          last_d      = req.run_last;
          word_d      = AW'(LW'(start_blk) >> BW);
          first_d     = 1'b1;
          last_word_d = AW'(lim_m1 >> BW);
          start_lo_d  = start_blk[BW-1:0];
          lim_lo_d    = lim_m1[BW-1:0];
          idx_bad_d   = (req.block_index == '0) || (LW'(req.block_index) >= lim);
          if (req.req_type == bba_pkg::REQ_FREE) begin
            state_d = S_FCHK;
          end else if (range_empty) begin
            state_d = S_FAIL;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr  = word_q + AW'(1);
        bit_mask = MAP_WORD_BITS'(1) << found_bit;
        if (found) begin
          mem_we       = 1'b1;
          mem_wdata    = map_word | bit_mask;
          res_status_d = bba_pkg::ST_DONE;
          res_blk_d    = BLOCK_W'({word_q, found_bit});
          if (used_q != NBW'(NUM_BLOCKS)) begin
            used_d = used_q + NBW'(1);
          end
          state_d = S_PUSH;
        end else if (word_q == last_word_q) begin
          res_status_d = bba_pkg::ST_FULL;
          res_blk_d    = '0;
          state_d      = S_PUSH;
        end else begin
          word_d  = word_q + AW'(1);
          first_d = 1'b0;
        end
      end
      S_FCHK: begin
        mem_waddr = AW'(idx_q >> BW);
        bit_mask  = MAP_WORD_BITS'(1) << idx_q[BW-1:0];
        res_blk_d = idx_q;
        if (idx_bad_q || ((map_word & bit_mask) == '0)) begin
          res_status_d = bba_pkg::ST_IGNORED;
        end else begin
          mem_we       = 1'b1;
          mem_wdata    = map_word & ~bit_mask;
          res_status_d = bba_pkg::ST_DONE;
          if (used_q != '0) begin
            used_d = used_q - NBW'(1);
          end
        end
        state_d = S_PUSH;
      end
      S_FAIL: begin
        res_status_d = bba_pkg::ST_FULL;
        res_blk_d    = '0;
        state_d      = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_q || rsp.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    first_q      <= first_d;
    last_word_q  <= last_word_d;
    start_lo_q   <= start_lo_d;
    lim_lo_q     <= lim_lo_d;
    idx_q        <= idx_d;
    idx_bad_q    <= idx_bad_d;
    last_q       <= last_d;
    res_status_q <= res_status_d;
    res_blk_q    <= res_blk_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_blk_q    <= res_blk_q;
      out_used_q   <= COUNT_W'(used_q);
      out_last_q   <= last_q;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.status       = out_status_q;
  assign rsp.block_number = out_blk_q;
  assign rsp.used_blocks  = out_used_q;
  assign rsp.run_last_out = out_last_q;

`include "bitmap_block_allocator_core_assert.svh"

  // A granted allocation never hands out block zero, and a failed one reports it.
  `BBA_ASSERT_SAME(a_done_nonzero, rsp.valid && (rsp.status == bba_pkg::ST_DONE), rsp.block_number != '0)
  `BBA_ASSERT_SAME(a_full_zero, rsp.valid && (rsp.status == bba_pkg::ST_FULL), rsp.block_number == '0)
  // The map is written only by the scan or the free check.
  `BBA_ASSERT_SAME(a_write_state, mem_we, (state_q == S_SCAN) || (state_q == S_FCHK))
  // The used count moves only together with a map write.
  `BBA_ASSERT_SAME(a_count_write, used_d != used_q, mem_we)

endmodule
